>>> hw/rtl/fdpb_pkg.sv
// Shared types, constants and helpers for the frequency-domain power beamformer.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package fdpb_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int MAX_FREQS_DEF      = 256;
	localparam int MAX_ANTENNAS_DEF   = 16;
	localparam int MAX_DIRECTIONS_DEF = 16;
	localparam int SAMPLE_BITS_DEF    = 16;

	// Accumulator bank: one complex accumulator per formed direction
	localparam int ACC_DEPTH = 16;
	localparam int ACC_AW    = $clog2(ACC_DEPTH);
	localparam int ACC_W     = 38;
	// Sum of accumulator and product, wide enough for a 24-bit sample
	localparam int SUM_W     = 42;

	// Weight word: real part in the upper half, imaginary in the lower half
	localparam int WEIGHT_W  = 32;
	localparam int COEF_W    = 16;

	// Power path widths
	localparam int FRAC_BITS = 15;
	localparam int RND_W     = ACC_W + 1 - FRAC_BITS;
	localparam int SQ_W      = 2 * RND_W - 3;
	localparam int MAG_W     = SQ_W + 1;
	localparam int NORM_W    = 16;
	localparam int PROD_W    = MAG_W + NORM_W;
	localparam int POWER_W   = 48;

	// Result queue
	localparam int RES_FIFO_DEPTH = 32;
	localparam int FIFO_AW        = $clog2(RES_FIFO_DEPTH);
	localparam int FIFO_CW        = $clog2(RES_FIFO_DEPTH + 1);

	// Stream word widths
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_PAD_W  = OUT_DATA_W - 8 - ACC_AW - POWER_W;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ANTENNAS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIRECTIONS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NORM_SCALE     = 2'd2;

	// Saturation bounds of the accumulator, in the width of the sum
	localparam logic signed [SUM_W-1:0] ACC_HI =
		{{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] ACC_LO =
		{{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

	typedef enum logic {
		CMD_WEIGHT = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_ISSUE
	} seq_state_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] re;
		logic signed [ACC_W-1:0] im;
	} acc_pair_t;

	typedef struct packed {
		logic [7:0]        freq;
		logic [ACC_AW-1:0] dir;
		logic              last;
	} res_meta_t;

	// Finished accumulator handed to the power path
	typedef struct packed {
		logic      valid;
		res_meta_t meta;
		acc_pair_t acc;
	} pw_in_t;

	typedef struct packed {
		logic busy;
		logic room;
	} pw_status_t;

	typedef struct packed {
		res_meta_t          meta;
		logic [POWER_W-1:0] power;
	} result_t;

	// Clamp a sum to the signed accumulator range
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] y;
		begin
			y = x;
			if (x > ACC_HI) begin
				y = ACC_HI;
			end else if (x < ACC_LO) begin
				y = ACC_LO;
			end
			return y[ACC_W-1:0];
		end
	endfunction

endpackage

>>> hw/rtl/fdpb_weight_ram.sv
// Weight memory of the beamformer: one write port, one registered read port.
// Depends on fdpb_pkg for the word width.
`timescale 1ns / 1ps

module fdpb_weight_ram #(
	parameter int DEPTH  = 65536,
	parameter int ADDR_W = 16
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [ADDR_W-1:0]             waddr,
	input  logic [fdpb_pkg::WEIGHT_W-1:0] wdata,
	input  logic                          re,
	input  logic [ADDR_W-1:0]             raddr,
	output logic [fdpb_pkg::WEIGHT_W-1:0] rdata
);
	import fdpb_pkg::*;

	logic [WEIGHT_W-1:0] mem [DEPTH];

	// Write a weight word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/fdpb_acc_ram.sv
// Accumulator bank: one complex accumulator per direction, registered read.
// Depends on fdpb_pkg; entries read as zero until first written after reset.
`timescale 1ns / 1ps

module fdpb_acc_ram (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [fdpb_pkg::ACC_AW-1:0] waddr,
	input  fdpb_pkg::acc_pair_t         wdata,
	input  logic                        re,
	input  logic [fdpb_pkg::ACC_AW-1:0] raddr,
	output fdpb_pkg::acc_pair_t         rdata
);
	import fdpb_pkg::*;

	acc_pair_t            mem [ACC_DEPTH];
	logic [ACC_DEPTH-1:0] vld_q;

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// Store accumulator pairs
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read; an entry not yet written reads as zero
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= vld_q[raddr] ? mem[raddr] : '0;
		end
	end

endmodule

>>> hw/rtl/fdpb_power.sv
// Power path and result queue: rounding, squared magnitude, scaling.
// Depends on fdpb_pkg; fed by the accumulate stage of the top level.
`timescale 1ns / 1ps

module fdpb_power (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fdpb_pkg::pw_in_t                pin,
	input  logic [fdpb_pkg::NORM_W-1:0]     norm_scale,
	output fdpb_pkg::pw_status_t            status,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fdpb_pkg::OUT_DATA_W-1:0] m_tdata,  // freq_out, dir_out, power
	output logic                            m_tlast
);
	import fdpb_pkg::*;

	logic v_s3, v_s4, v_s5, v_s6, v_s7;
	res_meta_t meta_s3, meta_s4, meta_s5, meta_s6, meta_s7;
	acc_pair_t acc_s3;
	logic signed [RND_W-1:0] r_s4, i_s4;
	logic [SQ_W-1:0]   rr_s5, ii_s5;
	logic [MAG_W-1:0]  mag_s6;
	logic [PROD_W-1:0] prod_s7;

	logic signed [ACC_W:0]     rnd_re, rnd_im;
	logic signed [2*RND_W-1:0] sq_re, sq_im;
	logic [PROD_W-1:0]         prod_rnd;
	logic [POWER_W-1:0]        power_d;

	result_t              res_q [RES_FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 push, pop;
	result_t              head;

	// Round each part to an integer, floor((x + 2^14) / 2^15)
	assign rnd_re = {acc_s3.re[ACC_W-1], acc_s3.re} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
	assign rnd_im = {acc_s3.im[ACC_W-1], acc_s3.im} + (ACC_W+1)'(1 << (FRAC_BITS - 1));

	assign sq_re = r_s4 * r_s4;
	assign sq_im = i_s4 * i_s4;

	// Round the scaled power; it stays below 2^46, so it fits the 48-bit field unclamped
	assign prod_rnd = prod_s7 + PROD_W'(1 << (NORM_W - 1));
	assign power_d  = POWER_W'(prod_rnd[PROD_W-1:NORM_W]);

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s3 <= pin.valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		meta_s3 <= pin.meta;
		acc_s3  <= pin.acc;
		meta_s4 <= meta_s3;
		r_s4    <= rnd_re[ACC_W:FRAC_BITS];
		i_s4    <= rnd_im[ACC_W:FRAC_BITS];
		meta_s5 <= meta_s4;
		rr_s5   <= sq_re[SQ_W-1:0];
		ii_s5   <= sq_im[SQ_W-1:0];
		meta_s6 <= meta_s5;
		mag_s6  <= MAG_W'(rr_s5) + MAG_W'(ii_s5);
		meta_s7 <= meta_s6;
		prod_s7 <= PROD_W'(mag_s6) * PROD_W'(norm_scale);
	end

	assign push = v_s7;
	assign pop  = m_tvalid && m_tready;

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CW'(1);
			end
		end
	end

	// Store results
	always_ff @(posedge clk) begin
		if (push) begin
			res_q[wr_ptr_q] <= '{meta: meta_s7, power: power_d};
		end
	end

	assign head     = res_q[rd_ptr_q];
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, head.power, head.meta.dir, head.meta.freq};
	assign m_tlast  = head.meta.last;

	// Busy while any stage holds a word; room for a full set of directions
	assign status.busy = v_s3 || v_s4 || v_s5 || v_s6 || v_s7;
	assign status.room = (count_q <= FIFO_CW'(RES_FIFO_DEPTH - ACC_DEPTH));

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (count_q < FIFO_CW'(RES_FIFO_DEPTH)))
		else $error("result queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.room |-> ##1 (count_q <= FIFO_CW'(RES_FIFO_DEPTH)))
		else $error("result queue count out of range");
`endif

endmodule

>>> hw/rtl/freq_domain_power_beamformer.sv
// Top level of the frequency-domain power beamformer: stream ports, registers,
// direction sequencer and complex multiply-accumulate. Uses fdpb_pkg and all submodules.
`timescale 1ns / 1ps

// A weight word (tuser 0) is written to the weight memory. A data word (tuser 1)
// is processed one direction per cycle by a single complex multiply-accumulate
// fed from the weight memory read port. No new word is taken until the
// multiply-accumulate pipeline is empty and, after the last antenna, the power
// pipeline has drained too. The last antenna of
// a frequency yields num_directions result words, with tlast on the final
// direction. Results wait in a 32-word queue; input is taken only while the queue
// has room for a full set of 16 results. No clearing pass follows reset: the
// weight memory must be written before use, and the accumulators carry valid bits.
module freq_domain_power_beamformer #(
	parameter int MAX_FREQS      = fdpb_pkg::MAX_FREQS_DEF,
	parameter int MAX_ANTENNAS   = fdpb_pkg::MAX_ANTENNAS_DEF,
	parameter int MAX_DIRECTIONS = fdpb_pkg::MAX_DIRECTIONS_DEF,
	parameter int SAMPLE_BITS    = fdpb_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// freq_index, ant_index, dir_index, val_re, val_im
	input  logic [fdpb_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                              s_tuser,  // cmd
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// freq_out, dir_out, power
	output logic [fdpb_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fdpb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fdpb_pkg::NORM_W-1:0]       cfg_data
);
	import fdpb_pkg::*;

	localparam int MEM_DEPTH = MAX_FREQS * MAX_ANTENNAS * MAX_DIRECTIONS;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int PW        = SAMPLE_BITS + COEF_W;
	localparam int DIR_CAP   = (MAX_DIRECTIONS < ACC_DEPTH) ? MAX_DIRECTIONS : ACC_DEPTH;
	localparam int SMAX      = (1 << (SAMPLE_BITS - 1)) - 1;
	localparam int SMIN      = -(1 << (SAMPLE_BITS - 1));

	// Configuration registers
	logic [4:0]        num_ant_q, num_dir_q;
	logic [NORM_W-1:0] norm_q;
	logic [4:0]        eff_ant, eff_dir;

	// Input word fields
	cmd_t              in_cmd;
	logic [7:0]        in_freq;
	logic [3:0]        in_ant, in_dir;
	logic signed [15:0] in_re, in_im;
	logic              accept, wt_ok, samp_ok, start;
	logic [31:0]       lin_base;
	logic signed [31:0] re32, im32;

	// Sequencer
	seq_state_t        state_q, state_d;
	logic              issue, last_issue;
	logic [ACC_AW-1:0] dcnt_q;

	// Per-sample context
	logic [ADDR_W-1:0]             base_q;
	logic signed [SAMPLE_BITS-1:0] samp_re_q, samp_im_q;
	logic [7:0]                    freq_q;
	logic                          ant0_q, fin_q;

	// MAC pipeline
	logic              v_s1, v_s2;
	logic [ACC_AW-1:0] d_s1, d_s2;
	logic              lastdir_s1, lastdir_s2;
	logic signed [PW-1:0] rr_s2, ii_s2, ri_s2, ir_s2;
	acc_pair_t         acc_s2;
	logic [WEIGHT_W-1:0] w_rdata;
	logic signed [COEF_W-1:0] w_re, w_im;
	acc_pair_t         acc_rdata, acc_new;
	logic signed [SUM_W-1:0] p_re, p_im, add_re, add_im;

	pw_in_t            pin;
	pw_status_t        pw_status;

	// Unpack the input word
	assign in_cmd  = cmd_t'(s_tuser);
	assign in_freq = s_tdata[7:0];
	assign in_ant  = s_tdata[11:8];
	assign in_dir  = s_tdata[15:12];
	assign in_re   = s_tdata[31:16];
	assign in_im   = s_tdata[47:32];

	assign cfg_ready = 1'b1;

	// Write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ant_q <= 5'd16;
			num_dir_q <= 5'd16;
			norm_q    <= NORM_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUM_ANTENNAS:   num_ant_q <= cfg_data[4:0];
				CFG_NUM_DIRECTIONS: num_dir_q <= cfg_data[4:0];
				CFG_NORM_SCALE:     norm_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the counts to the supported range
	always_comb begin
		if (num_ant_q == 5'd0) begin
			eff_ant = 5'd1;
		end else if ({27'd0, num_ant_q} > 32'(MAX_ANTENNAS)) begin
			eff_ant = 5'(MAX_ANTENNAS);
		end else begin
			eff_ant = num_ant_q;
		end
		if (num_dir_q == 5'd0) begin
			eff_dir = 5'd1;
		end else if ({27'd0, num_dir_q} > 32'(DIR_CAP)) begin
			eff_dir = 5'(DIR_CAP);
		end else begin
			eff_dir = num_dir_q;
		end
	end

	// Range checks and memory addressing of the input word
	assign accept   = s_tvalid && s_tready;
	assign wt_ok    = ({24'd0, in_freq} < 32'(MAX_FREQS)) &&
	                  ({28'd0, in_ant} < 32'(MAX_ANTENNAS)) &&
	                  ({28'd0, in_dir} < 32'(MAX_DIRECTIONS));
	assign samp_ok  = ({24'd0, in_freq} < 32'(MAX_FREQS)) && ({1'b0, in_ant} < eff_ant);
	assign start    = accept && (in_cmd == CMD_SAMPLE) && samp_ok;
	assign lin_base = ({24'd0, in_freq} * 32'(MAX_ANTENNAS) + {28'd0, in_ant}) *
	                  32'(MAX_DIRECTIONS);

	// Saturate the sample to its working width
	always_comb begin
		re32 = 32'(in_re);
		im32 = 32'(in_im);
		if (re32 > SMAX) re32 = SMAX;
		if (re32 < SMIN) re32 = SMIN;
		if (im32 > SMAX) im32 = SMAX;
		if (im32 < SMIN) im32 = SMIN;
	end

	// Next state of the sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_ISSUE;
			ST_ISSUE: if (last_issue) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs; take input only with the pipelines empty
	always_comb begin
		s_tready   = 1'b0;
		issue      = 1'b0;
		last_issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = !v_s1 && !v_s2 && !pw_status.busy && pw_status.room;
			end
			ST_ISSUE: begin
				issue      = 1'b1;
				last_issue = ({1'b0, dcnt_q} == eff_dir - 5'd1);
			end
			default: ;
		endcase
	end

	// Sequencer state, direction counter and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dcnt_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				dcnt_q <= '0;
			end else if (issue) begin
				dcnt_q <= dcnt_q + ACC_AW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// Hold the sample context for its directions
	always_ff @(posedge clk) begin
		if (start) begin
			base_q    <= ADDR_W'(lin_base);
			samp_re_q <= SAMPLE_BITS'(re32);
			samp_im_q <= SAMPLE_BITS'(im32);
			freq_q    <= in_freq;
			ant0_q    <= (in_ant == 4'd0);
			fin_q     <= ({1'b0, in_ant} == eff_ant - 5'd1);
		end
	end

	fdpb_weight_ram #(
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_weight_ram (
		.clk   (clk),
		.we    (accept && (in_cmd == CMD_WEIGHT) && wt_ok),
		.waddr (ADDR_W'(lin_base + {28'd0, in_dir})),
		.wdata ({in_re, in_im}),
		.re    (issue),
		.raddr (base_q + ADDR_W'(dcnt_q)),
		.rdata (w_rdata)
	);

	fdpb_acc_ram u_acc_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (v_s2),
		.waddr  (d_s2),
		.wdata  (acc_new),
		.re     (issue),
		.raddr  (dcnt_q),
		.rdata  (acc_rdata)
	);

	assign w_re = w_rdata[WEIGHT_W-1:COEF_W];
	assign w_im = w_rdata[COEF_W-1:0];

	// Multiply the sample by the weight of this direction
	always_ff @(posedge clk) begin
		d_s1       <= dcnt_q;
		lastdir_s1 <= last_issue;
		d_s2       <= d_s1;
		lastdir_s2 <= lastdir_s1;
		rr_s2      <= samp_re_q * w_re;
		ii_s2      <= samp_im_q * w_im;
		ri_s2      <= samp_re_q * w_im;
		ir_s2      <= samp_im_q * w_re;
		acc_s2     <= acc_rdata;
	end

	// Accumulate with saturation; antenna zero starts a fresh sum
	always_comb begin
		p_re   = SUM_W'(rr_s2) - SUM_W'(ii_s2);
		p_im   = SUM_W'(ri_s2) + SUM_W'(ir_s2);
		add_re = ant0_q ? p_re : SUM_W'(acc_s2.re) + p_re;
		add_im = ant0_q ? p_im : SUM_W'(acc_s2.im) + p_im;
		acc_new.re = sat_acc(add_re);
		acc_new.im = sat_acc(add_im);
	end

	// Hand final sums to the power path
	assign pin.valid     = v_s2 && fin_q;
	assign pin.meta.freq = freq_q;
	assign pin.meta.dir  = d_s2;
	assign pin.meta.last = lastdir_s2;
	assign pin.acc       = acc_new;

	fdpb_power u_power (
		.clk        (clk),
		.arst_n     (arst_n),
		.pin        (pin),
		.norm_scale (norm_q),
		.status     (pw_status),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

`ifndef SYNTHESIS
	a_ready_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!v_s1 && !v_s2))
		else $error("input taken with accumulate pipeline busy");

	a_no_acc_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && v_s2) |-> (dcnt_q != d_s2))
		else $error("accumulator read and write hit the same entry");

	a_dir_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> ({1'b0, dcnt_q} < eff_dir))
		else $error("direction counter past active directions");
`endif

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the frequency-domain power beamformer: stream stimulus
// with random idling, an in-bench beam power predictor and field-by-field checking.
// Depends on fdpb_pkg and freq_domain_power_beamformer.
`timescale 1ns / 1ps

module tb_top;
	import fdpb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int NUM_PHASES = 8;
	localparam int SETTLE_CYCLES = 30;
	localparam int LONG_HOLD = 2000;
	localparam longint ACC_TOP = 64'sd137438953471;
	localparam longint ACC_BOT = -64'sd137438953472;
	localparam logic [63:0] POWER_TOP = 64'h0000_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		ROW_REG,
		ROW_WEIGHT,
		ROW_SAMPLE
	} row_kind_t;

	// One directed step; pwr is only meaningful where chk is set
	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] ridx;
		logic [15:0]          rval;
		logic [7:0]           freq;
		logic [3:0]           ant;
		logic [3:0]           dir;
		logic [15:0]          re;
		logic [15:0]          im;
		logic                 chk;
		logic [47:0]          pwr;
	} step_t;

	localparam int NUM_ROWS = 23;
	step_t dir_plan [NUM_ROWS] = '{
		// one antenna, one direction; upper data bits must be masked
		'{ROW_REG, CFG_NUM_ANTENNAS, 16'hFFE1, 8'd0, 4'd0, 4'd0, 16'h0, 16'h0, 1'b0, 48'd0},
		'{ROW_REG, CFG_NUM_DIRECTIONS, 16'd1, 8'd0, 4'd0, 4'd0, 16'h0, 16'h0, 1'b0, 48'd0},
		// weight of minus one, most negative sample, reset scale
		'{ROW_WEIGHT, CFG_UNUSED, 16'd0, 8'd255, 4'd0, 4'd0, 16'h8000, 16'h0000, 1'b0, 48'd0},
		'{ROW_SAMPLE, CFG_UNUSED, 16'd0, 8'd255, 4'd0, 4'd0, 16'h8000, 16'h8000, 1'b1,
			48'd8388608},
		'{ROW_SAMPLE, CFG_UNUSED, 16'd0, 8'd255, 4'd0, 4'd0, 16'h0000, 16'h0000, 1'b1, 48'd0},
		// zero scale kills any power
		'{ROW_REG, CFG_NORM_SCALE, 16'h0000, 8'd0, 4'd0, 4'd0, 16'h0, 16'h0, 1'b0, 48'd0},
		'{ROW_SAMPLE, CFG_UNUSED, 16'd0, 8'd255, 4'd0, 4'd0, 16'h7FFF, 16'h7FFF, 1'b1, 48'd0},
		'{ROW_REG, CFG_NORM_SCALE, 16'hFFFF, 8'd0, 4'd0, 4'd0, 16'h0, 16'h0, 1'b0, 48'd0},
		'{ROW_SAMPLE, CFG_UNUSED, 16'd0, 8'd255, 4'd0, 4'd0, 16'h7FFF, 16'h8000, 1'b0, 48'd0},
		'{ROW_WEIGHT, CFG_UNUSED, 16'd0, 8'd255, 4'd0, 4'd0, 16'h7FFF, 16'h7FFF, 1'b0, 48'd0},
		'{ROW_SAMPLE, CFG_UNUSED, 16'd0, 8'd255, 4'd0, 4'd0, 16'h8000, 16'h7FFF, 1'b0, 48'd0},
		// two antennas; zero directions clamps to one
		'{ROW_REG, CFG_NUM_ANTENNAS, 16'd2, 8'd0, 4'd0, 4'd0, 16'h0, 16'h0, 1'b0, 48'd0},
		'{ROW_REG, CFG_NUM_DIRECTIONS, 16'd0, 8'd0, 4'd0, 4'd0, 16'h0, 16'h0, 1'b0, 48'd0},
		'{ROW_WEIGHT, CFG_UNUSED, 16'd0, 8'd0, 4'd0, 4'd0, 16'h4000, 16'h0000, 1'b0, 48'd0},
		'{ROW_WEIGHT, CFG_UNUSED, 16'd0, 8'd0, 4'd1, 4'd0, 16'h0000, 16'h4000, 1'b0, 48'd0},
		// last antenna without antenna zero: adds onto old sums
		'{ROW_SAMPLE, CFG_UNUSED, 16'd0, 8'd0, 4'd1, 4'd0, 16'h0064, 16'h0000, 1'b0, 48'd0},
		// antenna beyond the count is ignored
		'{ROW_SAMPLE, CFG_UNUSED, 16'd0, 8'd0, 4'd2, 4'd5, 16'h1234, 16'h5678, 1'b0, 48'd0},
		'{ROW_SAMPLE, CFG_UNUSED, 16'd0, 8'd0, 4'd0, 4'd0, 16'h0002, 16'h0000, 1'b0, 48'd0},
		// real part sits at minus one: rounds to -1, power 1
		'{ROW_SAMPLE, CFG_UNUSED, 16'd0, 8'd0, 4'd1, 4'd0, 16'h0000, 16'h0004, 1'b1, 48'd1},
		// write past the register list, then zero antennas clamps to one
		'{ROW_REG, CFG_UNUSED, 16'hFFFF, 8'd0, 4'd0, 4'd0, 16'h0, 16'h0, 1'b0, 48'd0},
		'{ROW_REG, CFG_NUM_ANTENNAS, 16'd0, 8'd0, 4'd0, 4'd0, 16'h0, 16'h0, 1'b0, 48'd0},
		'{ROW_SAMPLE, CFG_UNUSED, 16'd0, 8'd0, 4'd1, 4'd0, 16'h7FFF, 16'h7FFF, 1'b0, 48'd0},
		'{ROW_SAMPLE, CFG_UNUSED, 16'd0, 8'd0, 4'd0, 4'd0, 16'hFFFF, 16'h0001, 1'b0, 48'd0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [NORM_W-1:0]     cfg_data;

	// Predictor state: registers, weights, per-direction complex sums
	logic [4:0]  ant_cfg = 5'd16;
	logic [4:0]  dir_cfg = 5'd16;
	logic [15:0] norm_cfg = 16'd256;
	logic [31:0] weight_tbl [0:65535];
	bit          weight_set [0:65535];
	longint      beam_re [16] = '{default: 0};
	longint      beam_im [16] = '{default: 0};
	result_t     pending_beams [$];

	int unsigned mismatch_cnt = 0;
	int unsigned items_sent = 0;
	bit          tx_steady = 1'b0;
	bit          rx_steady = 1'b0;

	freq_domain_power_beamformer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Time limit for the whole run
	initial begin : watchdog
		#(5_000_000);
		$display("== FAIL ==");
		$finish;
	end

	task automatic note_mismatch(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 40) $display("%0t mismatch: %s", $time, msg);
	endtask

	// Antenna and direction counts clamp to 1..16
	function automatic int unsigned clamp_count(logic [4:0] raw);
		if (raw == 5'd0) return 1;
		if (raw > 5'd16) return 16;
		return raw;
	endfunction

	function automatic longint clip38(longint x);
		if (x > ACC_TOP) return ACC_TOP;
		if (x < ACC_BOT) return ACC_BOT;
		return x;
	endfunction

	function automatic logic [15:0] rand_val();
		case ($urandom_range(0, 11))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Accumulate one sample into every active direction and queue the beam powers
	// when it closes the frequency. Returns 0 for an ignored sample.
	function automatic bit form_beams(logic [7:0] f, logic [3:0] a, logic [15:0] re,
			logic [15:0] im);
		int unsigned na, nd;
		int          d;
		longint      xr, xi, wr, wi, pr, pi, rr, ri, mag;
		logic [31:0] w;
		logic [63:0] pw;
		result_t     beam;
		na = clamp_count(ant_cfg);
		nd = clamp_count(dir_cfg);
		if (a >= na) return 1'b0;
		xr = longint'($signed(re));
		xi = longint'($signed(im));
		for (d = 0; d < nd; d++) begin
			w = weight_tbl[{f, a, 4'(d)}];
			wr = longint'($signed(w[31:16]));
			wi = longint'($signed(w[15:0]));
			pr = xr * wr - xi * wi;
			pi = xr * wi + xi * wr;
			if (a == 4'd0) begin
				beam_re[d] = clip38(pr);
				beam_im[d] = clip38(pi);
			end else begin
				beam_re[d] = clip38(beam_re[d] + pr);
				beam_im[d] = clip38(beam_im[d] + pi);
			end
		end
		if (a != na - 1) return 1'b1;
		for (d = 0; d < nd; d++) begin
			rr = (beam_re[d] + 16384) >>> 15;
			ri = (beam_im[d] + 16384) >>> 15;
			mag = rr * rr + ri * ri;
			pw = (64'(mag) * 64'(norm_cfg) + 64'd32768) >> 16;
			if (pw > POWER_TOP) pw = POWER_TOP;
			beam.meta.freq = f;
			beam.meta.dir = 4'(d);
			beam.meta.last = (d == nd - 1);
			beam.power = pw[47:0];
			pending_beams.push_back(beam);
		end
		return 1'b1;
	endfunction

	// Offer one input word after a random gap; valid stays high when no gap follows
	task automatic put_word(cmd_t c, logic [7:0] f, logic [3:0] a, logic [3:0] d,
			logic [15:0] re, logic [15:0] im);
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(0, 7);
		if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tuser <= c;
		s_tdata <= {im, re, d, a, f};
		s_tvalid <= 1'b1;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		if (c == CMD_WEIGHT) begin
			weight_tbl[{f, a, d}] = {re, im};
			weight_set[{f, a, d}] = 1'b1;
			items_sent++;
		end else if (form_beams(f, a, re, im)) begin
			items_sent++;
		end
	endtask

	// Write one register; keep valid up when another write follows at once
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val, bit more);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		if (!more) cfg_valid <= 1'b0;
		case (idx)
			CFG_NUM_ANTENNAS:   ant_cfg = val[4:0];
			CFG_NUM_DIRECTIONS: dir_cfg = val[4:0];
			CFG_NORM_SCALE:     norm_cfg = val;
			default: ;
		endcase
	endtask

	// Stop offering, wait for every pending beam, then let the last word drain
	task automatic drain_beams();
		s_tvalid <= 1'b0;
		while (pending_beams.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: random stalls, one long hold-off, check each beam word
	initial begin : sink
		int unsigned stall;
		int unsigned seen;
		logic        take;
		logic [63:0] word;
		logic        lst;
		result_t     want;
		stall = 0;
		seen = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			take = m_tvalid && m_tready;
			word = m_tdata;
			lst = m_tlast;
			@(posedge clk);
			if (take) begin
				seen++;
				if (pending_beams.size() == 0) begin
					note_mismatch($sformatf("beam word freq %0d dir %0d with none expected",
						word[7:0], word[8 +: ACC_AW]));
				end else begin
					want = pending_beams.pop_front();
					if (word[7:0] !== want.meta.freq)
						note_mismatch($sformatf("freq_out got %0d want %0d",
							word[7:0], want.meta.freq));
					if (word[8 +: ACC_AW] !== want.meta.dir)
						note_mismatch($sformatf("dir_out got %0d want %0d",
							word[8 +: ACC_AW], want.meta.dir));
					if (word[8 + ACC_AW +: POWER_W] !== want.power)
						note_mismatch($sformatf("power f%0d d%0d got %0d want %0d",
							want.meta.freq, want.meta.dir,
							word[8 + ACC_AW +: POWER_W], want.power));
					if (lst !== want.meta.last)
						note_mismatch($sformatf("tlast f%0d d%0d got %b want %b",
							want.meta.freq, want.meta.dir, lst, want.meta.last));
				end
				// hold off long once so the result queue fills and input stalls
				if (seen == 120) stall = LONG_HOLD;
				else stall = rx_steady ? 0 : $urandom_range(0, 7);
				if ($urandom_range(0, 47) == 0) rx_steady = !rx_steady;
			end else if (stall != 0) begin
				stall--;
			end
			m_tready <= (stall == 0);
		end
	end

	initial begin : stimulus
		int          k, ph, a, d, first, kind, frames;
		int unsigned na, nd, pool_n, phase_start;
		logic [4:0]  ant_raw, dir_raw;
		logic [15:0] norm_raw, v;
		logic [7:0]  f;
		logic [7:0]  pool [3];
		step_t       row;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= CMD_WEIGHT;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_NUM_ANTENNAS;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed steps
		for (k = 0; k < NUM_ROWS; k++) begin
			row = dir_plan[k];
			case (row.kind)
				ROW_REG: begin
					if (k == 0 || dir_plan[k - 1].kind != ROW_REG) drain_beams();
					write_reg(row.ridx, row.rval,
						k + 1 < NUM_ROWS && dir_plan[k + 1].kind == ROW_REG);
				end
				ROW_WEIGHT: begin
					put_word(CMD_WEIGHT, row.freq, row.ant, row.dir, row.re, row.im);
				end
				default: begin
					put_word(CMD_SAMPLE, row.freq, row.ant, row.dir, row.re, row.im);
					if (row.chk) pending_beams[pending_beams.size() - 1].power = row.pwr;
				end
			endcase
		end

		// Random phases, one register setting each
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			drain_beams();
			case (ph)
				0: begin ant_raw = 5'd3;  dir_raw = 5'd4;  norm_raw = 16'd256; end
				1: begin ant_raw = 5'd31; dir_raw = 5'd20; norm_raw = 16'hFFFF; end
				2: begin ant_raw = 5'd1;  dir_raw = 5'd16; norm_raw = 16'($urandom); end
				3: begin ant_raw = 5'd16; dir_raw = 5'd1;  norm_raw = 16'd1; end
				4: begin ant_raw = 5'd0;  dir_raw = 5'd0;  norm_raw = 16'($urandom); end
				5: begin
					ant_raw = 5'($urandom_range(0, 31));
					dir_raw = 5'($urandom_range(1, 8));
					norm_raw = 16'($urandom);
				end
				6: begin
					ant_raw = 5'($urandom_range(2, 6));
					dir_raw = 5'($urandom_range(1, 16));
					norm_raw = 16'($urandom);
				end
				default: begin ant_raw = 5'd2; dir_raw = 5'd2; norm_raw = 16'hFFFF; end
			endcase
			v = 16'($urandom);
			v[4:0] = ant_raw;
			write_reg(CFG_NUM_ANTENNAS, v, 1'b1);
			v = 16'($urandom);
			v[4:0] = dir_raw;
			write_reg(CFG_NUM_DIRECTIONS, v, 1'b1);
			write_reg(CFG_NORM_SCALE, norm_raw, 1'b0);
			na = clamp_count(ant_raw);
			nd = clamp_count(dir_raw);

			// few frequencies per phase keep weight loading cheap on wide settings
			pool_n = (na * nd > 64) ? 1 : 3;
			for (k = 0; k < 3; k++) pool[k] = 8'($urandom);
			frames = 0;
			phase_start = items_sent;
			while (items_sent - phase_start < 52 || frames < 2) begin
				f = pool[$urandom_range(0, pool_n - 1)];
				kind = $urandom_range(0, 9);
				if (kind <= 7) begin
					// full frame, or one that starts past antenna zero
					first = (kind == 7 && na > 1) ? $urandom_range(1, na - 1) : 0;
					for (a = first; a < na; a++) begin
						for (d = 0; d < nd; d++)
							if (!weight_set[{f, 4'(a), 4'(d)}])
								put_word(CMD_WEIGHT, f, 4'(a), 4'(d), rand_val(), rand_val());
						put_word(CMD_SAMPLE, f, 4'(a), 4'($urandom), rand_val(), rand_val());
						// cut the frame short now and then
						if (a != na - 1 && $urandom_range(0, 23) == 0) break;
					end
					frames++;
				end else if (kind == 8 && na < 16) begin
					put_word(CMD_SAMPLE, f, 4'($urandom_range(na, 15)), 4'($urandom),
						rand_val(), rand_val());
				end else begin
					repeat ($urandom_range(1, 3))
						put_word(CMD_WEIGHT, 8'($urandom), 4'($urandom), 4'($urandom),
							rand_val(), rand_val());
				end
			end

			// Drive both accumulators into saturation, one up and one down
			if (ph == NUM_PHASES - 1) begin
				f = pool[0];
				put_word(CMD_WEIGHT, f, 4'd1, 4'd0, 16'h8000, 16'h7FFF);
				put_word(CMD_WEIGHT, f, 4'd1, 4'd1, 16'h7FFF, 16'h8000);
				repeat (70) put_word(CMD_SAMPLE, f, 4'd1, 4'($urandom), 16'h8000, 16'h8000);
			end
		end

		drain_beams();
		if (mismatch_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/fdpb_pkg.sv
hw/rtl/fdpb_weight_ram.sv
hw/rtl/fdpb_acc_ram.sv
hw/rtl/fdpb_power.sv
hw/rtl/freq_domain_power_beamformer.sv
tb/sv/tb_top.sv
